// ----- hw/rtl/cfpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_pkg
// Shared types, codes and cycle tables of the cube face permutation core.
// ----------------------------------------------------------------------------
package cfpc_pkg;

    localparam int NumCells  = 54;
    localparam int CycleLen  = 12;
    localparam int IdxW      = 6;
    localparam int ByteW     = 8;
    localparam int StepShift = 3;

    // opcodes
    localparam logic [1:0] OpWrite  = 2'd0;
    localparam logic [1:0] OpRotate = 2'd1;
    localparam logic [1:0] OpRead   = 2'd2;

    // rotate directions
    localparam logic [1:0] DirNone  = 2'd0;
    localparam logic [1:0] DirVert  = 2'd1;
    localparam logic [1:0] DirHoriz = 2'd2;
    localparam logic [1:0] DirTwist = 2'd3;

    localparam logic [IdxW-1:0] LastCell = IdxW'(NumCells - 1);

    localparam int VertBase [CycleLen] = '{0, 3, 6, 12, 24, 36, 45, 48, 51, 44, 32, 20};
    localparam int VertStep [CycleLen] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, -1, -1, -1};
    localparam int TwistBase[CycleLen] = '{6, 7, 8, 15, 27, 39, 47, 46, 45, 35, 23, 11};
    localparam int TwistStep[CycleLen] = '{-3, -3, -3, 1, 1, 1, 3, 3, 3, -1, -1, -1};

    typedef logic [NumCells-1:0][ByteW-1:0] t_cells;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IdxW-1:0]  cell_index;
        logic [ByteW-1:0] write_value;
        logic [1:0]       rotate_direction;
        logic [1:0]       rotate_column;
        logic [1:0]       rotate_times;
    } t_item;

    // Cell number at slot i of the cycle for direction dir (1..3), column col (0..2).
    function automatic int cycle_pos(input int dir, input int col, input int i);
        int p;
        p = 0;
        if (dir == 1) begin
            p = VertBase[i] + VertStep[i] * col;
        end else if (dir == 2) begin
            p = 9 + i + 12 * col;
        end else begin
            p = TwistBase[i] + TwistStep[i] * col;
        end
        if (p < 0 || p >= NumCells) begin
            p = 0;
        end
        return p;
    endfunction

    // Slot whose old content lands in slot i after a shift (shift < CycleLen).
    function automatic int src_slot(input int i, input int shift);
        int j;
        j = i + shift;
        if (j >= CycleLen) begin
            j = j - CycleLen;
        end
        return j;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cfpc_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_in_reg
// Input register: captures one item and holds it until the core advances.
// ----------------------------------------------------------------------------
module cfpc_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cfpc_pkg::t_item i_item,
    input  wire logic            i_advance,
    output logic                 o_valid,
    output cfpc_pkg::t_item      o_item
);

    logic            r_valid;
    cfpc_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cfpc_rotate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfpc_rotate
// Permutation network: every direction, column and count as a fixed wiring,
// then one selection by the item fields.
// ----------------------------------------------------------------------------
module cfpc_rotate (
    input  wire cfpc_pkg::t_cells i_cells,
    input  wire logic [1:0]       i_direction,
    input  wire logic [1:0]       i_column,
    input  wire logic [1:0]       i_times,
    output cfpc_pkg::t_cells      o_cells
);

    cfpc_pkg::t_cells w_rot [3][3][3];

    for (genvar gd = 1; gd <= 3; gd++) begin : g_dir
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            for (genvar gt = 1; gt <= 3; gt++) begin : g_cnt
                always_comb begin
                    w_rot[gd-1][gc][gt-1] = i_cells;
                    for (int i = 0; i < cfpc_pkg::CycleLen; i++) begin
                        w_rot[gd-1][gc][gt-1][
                            cfpc_pkg::IdxW'(cfpc_pkg::cycle_pos(gd, gc, i))] =
                            i_cells[cfpc_pkg::IdxW'(cfpc_pkg::cycle_pos(gd, gc,
                                cfpc_pkg::src_slot(i, cfpc_pkg::StepShift * gt)))];
                    end
                end
            end
        end
    end

    always_comb begin
        o_cells = i_cells;
        if (i_direction != cfpc_pkg::DirNone && i_column != 2'd0 && i_times != 2'd0) begin
            o_cells = w_rot[2'(i_direction - 2'd1)][2'(i_column - 2'd1)][2'(i_times - 2'd1)];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cube_face_permutation_cipher_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cube_face_permutation_cipher_core
// 54-byte cell store with write, read and cube-face rotate items.
// ----------------------------------------------------------------------------
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   in      | i_in_valid / o_in_ready    | opcode, cell_index, write_value,
//           |                            | rotate_direction/column/times
//   out     | o_out_valid / i_out_ready  | read_data (read items only)
//
// One item per cycle unless a read is held: an item is taken into the input
// register and applied to the cells from there; a read loads its byte into the
// output register as it is applied, and the result is offered from there.
// The rotate network is fully parallel. Reset clears the handshake state only;
// cells are undefined until written. A read item waits in the input register
// while the output register is full and stalled; writes and rotates pass.
// ----------------------------------------------------------------------------
module cube_face_permutation_cipher_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_opcode,
    input  wire logic [5:0] i_cell_index,
    input  wire logic [7:0] i_write_value,
    input  wire logic [1:0] i_rotate_direction,
    input  wire logic [1:0] i_rotate_column,
    input  wire logic [1:0] i_rotate_times,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_read_data
);

    cfpc_pkg::t_item  w_in_item;
    cfpc_pkg::t_item  w_item;
    logic             w_item_valid;
    logic             w_is_read;
    logic             w_in_range;
    logic             w_exec;
    cfpc_pkg::t_cells w_rotated;

    cfpc_pkg::t_cells r_cells;
    cfpc_pkg::t_cells n_cells;
    logic             r_out_valid;
    logic [7:0]       r_out_data;

    assign w_in_item.opcode           = i_opcode;
    assign w_in_item.cell_index       = i_cell_index;
    assign w_in_item.write_value      = i_write_value;
    assign w_in_item.rotate_direction = i_rotate_direction;
    assign w_in_item.rotate_column    = i_rotate_column;
    assign w_in_item.rotate_times     = i_rotate_times;

    cfpc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_exec),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    cfpc_rotate u_rotate (
        .i_cells     (r_cells),
        .i_direction (w_item.rotate_direction),
        .i_column    (w_item.rotate_column),
        .i_times     (w_item.rotate_times),
        .o_cells     (w_rotated)
    );

    assign w_is_read  = (w_item.opcode == cfpc_pkg::OpRead);
    assign w_in_range = (w_item.cell_index <= cfpc_pkg::LastCell);
    // hold a read while the result slot is full and stalled
    assign w_exec     = w_item_valid && (!w_is_read || !r_out_valid || i_out_ready);

    always_comb begin
        n_cells = r_cells;
        if (w_item.opcode == cfpc_pkg::OpWrite) begin
            if (w_in_range) begin
                n_cells[w_item.cell_index] = w_item.write_value;
            end
        end else if (w_item.opcode == cfpc_pkg::OpRotate) begin
            n_cells = w_rotated;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_cells <= n_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= w_exec && w_is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_is_read) begin
            r_out_data <= w_in_range ? r_cells[w_item.cell_index] : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule
`default_nettype wire
